// ----- sv/smoothed_zscore_peak_detector_defines.svh -----
// Assertion macros shared by the peak detector modules.
`ifndef SMOOTHED_ZSCORE_PEAK_DETECTOR_DEFINES_SVH
`define SMOOTHED_ZSCORE_PEAK_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle property, checked outside reset.
`define SZPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle implication, checked outside reset.
`define SZPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SZPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SZPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/szpd_pkg.sv -----
// Shared types and constants of the smoothed z-score peak detector.
package szpd_pkg;

    // Configuration register indexes and field widths
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 17;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_THRESHOLD     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_INFLUENCE     = 2'd2;

    localparam int unsigned WL_BITS    = 9;
    localparam int unsigned THR_BITS   = 16;
    localparam int unsigned INFL_BITS  = 17;
    localparam int unsigned INFL_FRAC  = 16;

    localparam logic [WL_BITS-1:0]   RST_WINDOW_LENGTH = 9'd150;
    localparam logic [THR_BITS-1:0]  RST_THRESHOLD     = 16'd10240;
    localparam logic [INFL_BITS-1:0] RST_INFLUENCE     = 17'd164;
    localparam logic [INFL_BITS-1:0] INFL_ONE          = 17'd65536;

    // Threshold squared is Q8.24
    localparam int unsigned THR_SQ_BITS  = 2 * THR_BITS;
    localparam int unsigned THR_SQ_SHIFT = 24;

    // Digit width of the shared multiplier
    localparam int unsigned DIGIT_BITS = 32;

    // Output word
    localparam int unsigned PEAK_BITS = 2;
    localparam int unsigned OUT_TDATA_BITS = 8;
    localparam logic [PEAK_BITS-1:0] PEAK_NONE  = 2'b00;
    localparam logic [PEAK_BITS-1:0] PEAK_ABOVE = 2'b01;
    localparam logic [PEAK_BITS-1:0] PEAK_BELOW = 2'b11;

    // Products formed on the shared multiplier, in issue order
    typedef enum logic [2:0] {
        OP_DM2 = 3'd0,  // |d| squared
        OP_SS  = 3'd1,  // |sum| squared
        OP_LQ  = 3'd2,  // length times square sum
        OP_TT  = 3'd3,  // threshold squared
        OP_LHS = 3'd4,  // (length - 1) times |d| squared
        OP_VL  = 3'd5,  // length times variance numerator
        OP_RHS = 3'd6   // threshold squared times the above
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    prep;
        logic    mul_step;
        t_mul_op op;
        logic    cmp;
        logic    sqr;
        logic    upd;
    } t_dp_cmd;

    typedef struct packed {
        logic warm;
        logic mul_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/smoothed_zscore_peak_detector.sv -----
// Top level of the smoothed z-score peak detector.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   s       | in        | i_s_tvalid / o_s_tready   | i_s_tdata: sample
//   m       | out       | o_m_tvalid / i_m_tready   | o_m_tdata: peak_signal, tuser: warming_up
//   cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each word is stepped through prepare, the products on the shared multiplier (32-bit digit
// steps, 11 at the default sizes), compare, square and update before the next is accepted;
// during warm-up the multiplier is skipped.
// The result sits in an output register; a new word is accepted while it waits, and the
// sequencer holds before its update step until that register is free.
// Reset is synchronous, active low; the ring needs no clearing pass.
// Configuration writes are always taken.
`include "smoothed_zscore_peak_detector_defines.svh"

module smoothed_zscore_peak_detector #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // slave side
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]      i_s_tdata,   // sample
    // master side
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    output logic [szpd_pkg::OUT_TDATA_BITS-1:0]           o_m_tdata,   // peak_signal
    output logic [0:0]                                    o_m_tuser,   // warming_up
    // configuration writes
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [szpd_pkg::CFG_INDEX_BITS-1:0]           i_cfg_index,
    input  logic [szpd_pkg::CFG_DATA_BITS-1:0]            i_cfg_data
);

    szpd_pkg::t_dp_cmd              cmd;
    szpd_pkg::t_dp_status           status;
    logic [szpd_pkg::PEAK_BITS-1:0] peak_signal;
    logic                           warming_up;

    szpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    szpd_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      ($signed(i_s_tdata[SAMPLE_BITS-1:0])),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_peak_signal (peak_signal),
        .o_warming_up  (warming_up)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = szpd_pkg::OUT_TDATA_BITS'(peak_signal);
    assign o_m_tuser   = warming_up;

endmodule

// ----- sv/szpd_ctrl.sv -----
// Peak detector sequencer: steps a word through prepare, multiply, compare, square and update.
`include "smoothed_zscore_peak_detector_defines.svh"

module szpd_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  szpd_pkg::t_dp_status   i_status,
    output szpd_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MUL  = 6'b000100,
        S_CMP  = 6'b001000,
        S_SQR  = 6'b010000,
        S_UPD  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    szpd_pkg::t_mul_op r_op, n_op;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        o_cmd    = '0;
        o_cmd.op = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_op       = szpd_pkg::OP_DM2;
                // skip the statistics while the window fills
                n_state    = i_status.warm ? S_CMP : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    if (r_op == szpd_pkg::OP_RHS) begin
                        n_state = S_CMP;
                    end else begin
                        n_op = szpd_pkg::t_mul_op'(r_op + 3'd1);
                    end
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_SQR;
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= szpd_pkg::OP_DM2;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    `SZPD_ASSERT(a_cmp_after_rhs, i_clk, i_rst_n, (r_state == S_CMP && !i_status.warm) |-> (r_op == szpd_pkg::OP_RHS), "compare reached before the last product")
    `SZPD_ASSERT(a_upd_out_free, i_clk, i_rst_n, (r_state == S_UPD) |-> i_status.out_free, "update while output register is full")
    `SZPD_ASSERT_NEXT(a_prep_next, i_clk, i_rst_n, r_state == S_PREP, r_state == S_MUL || r_state == S_CMP, "bad step after prepare")

endmodule

// ----- sv/szpd_datapath.sv -----
// Datapath of the peak detector: window ring, running sums, digit multiplier and output register.
`include "smoothed_zscore_peak_detector_defines.svh"

module szpd_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic signed [SAMPLE_BITS-1:0]             i_sample,
    input  logic                                      i_cfg_valid,
    input  logic [szpd_pkg::CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  logic [szpd_pkg::CFG_DATA_BITS-1:0]        i_cfg_data,
    input  szpd_pkg::t_dp_cmd                         i_cmd,
    output szpd_pkg::t_dp_status                      o_status,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [szpd_pkg::PEAK_BITS-1:0]            o_peak_signal,
    output logic                                      o_warming_up
);

    localparam int SB    = SAMPLE_BITS;
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int SW    = SB + LW;
    localparam int QW    = 2 * SB + LW;
    localparam int PW    = 2 * SW;
    localparam int VW    = QW + LW;
    localparam int LHW   = PW + LW;
    localparam int RLW   = QW + 2 * LW;
    localparam int TSW   = szpd_pkg::THR_SQ_BITS;
    localparam int CW    = RLW + TSW;
    localparam int DG    = szpd_pkg::DIGIT_BITS;
    localparam int AMW   = (SW > TSW) ? SW : TSW;
    localparam int NDMAX = (RLW + DG - 1) / DG;
    localparam int BPW   = NDMAX * DG;
    localparam int DIW   = $clog2(NDMAX + 1);
    localparam int ND_SW = (SW + DG - 1) / DG;
    localparam int ND_QW = (QW + DG - 1) / DG;
    localparam int ND_TH = (szpd_pkg::THR_BITS + DG - 1) / DG;
    localparam int ND_PW = (PW + DG - 1) / DG;
    localparam int ND_VW = (VW + DG - 1) / DG;
    localparam int MXW   = SB + szpd_pkg::INFL_BITS + 2;
    localparam int EW    = (LW > szpd_pkg::WL_BITS) ? LW : szpd_pkg::WL_BITS;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_WINDOW);
    localparam int LEN_RST_I = (szpd_pkg::RST_WINDOW_LENGTH > MAX_WINDOW) ?
                               MAX_WINDOW : int'(szpd_pkg::RST_WINDOW_LENGTH);
    localparam logic [LW-1:0] LEN_RST = LW'(LEN_RST_I);

    // configuration
    logic [LW-1:0]                    r_len;
    logic [szpd_pkg::THR_BITS-1:0]    r_thr;
    logic [szpd_pkg::INFL_BITS-1:0]   r_infl;

    // window state
    logic signed [SB-1:0]  r_ring [MAX_WINDOW];
    logic [AW-1:0]         r_slot;
    logic [LW-1:0]         r_fill;
    logic signed [SW-1:0]  r_sum;
    logic [QW-1:0]         r_sq;
    logic signed [SB-1:0]  r_last;
    logic signed [SB-1:0]  r_rd;
    logic [2*SB-1:0]       r_old_sq;

    // per-word registers
    logic signed [SB-1:0]  r_x;
    logic                  r_dpos;
    logic [SW-1:0]         r_dm;
    logic [SW-1:0]         r_sm;
    logic signed [MXW-1:0] r_mixp;
    logic [DIW-1:0]        r_dig;
    logic [CW-1:0]         r_acc;
    logic [PW-1:0]         r_p1;
    logic [PW-1:0]         r_ss;
    logic [VW-1:0]         r_lq;
    logic [TSW-1:0]        r_tt;
    logic [LHW-1:0]        r_lhs;
    logic [VW-1:0]         r_var;
    logic [RLW-1:0]        r_vl;
    logic [CW-1:0]         r_rhs;
    logic signed [SB-1:0]  r_filt;
    logic [szpd_pkg::PEAK_BITS-1:0] r_sig;
    logic [2*SB-1:0]       r_fsq;

    // output register
    logic                  r_out_valid;
    logic [szpd_pkg::PEAK_BITS-1:0] r_out_sig;
    logic                  r_out_warm;

    logic warm;
    assign warm = (r_fill < r_len);

    // clamp of a written window length
    logic [EW-1:0] wl_ext;
    logic [LW-1:0] wl_eff;
    always_comb begin
        wl_ext = EW'(i_cfg_data[szpd_pkg::WL_BITS-1:0]);
        if (wl_ext < EW'(2)) begin
            wl_eff = LW'(2);
        end else if (wl_ext > MAX_E) begin
            wl_eff = LW'(MAX_WINDOW);
        end else begin
            wl_eff = wl_ext[LW-1:0];
        end
    end

    logic [szpd_pkg::INFL_BITS-1:0] infl_eff;
    assign infl_eff = (i_cfg_data > szpd_pkg::INFL_ONE) ? szpd_pkg::INFL_ONE : i_cfg_data;

    // prepare: deviation, sum magnitude, influence product
    logic signed [SW:0]       lx;
    logic signed [SW:0]       dev;
    logic signed [SW:0]       dev_neg;
    logic signed [SW-1:0]     sum_neg;
    logic signed [SB:0]       diff;
    logic signed [szpd_pkg::INFL_BITS:0] infl_s;
    logic signed [MXW-1:0]    mixp;
    always_comb begin
        lx      = $signed({1'b0, r_len}) * r_x;
        dev     = lx - (SW + 1)'(r_sum);
        dev_neg = -dev;
        sum_neg = -r_sum;
        diff    = (SB + 1)'(r_x) - (SB + 1)'(r_last);
        infl_s  = $signed({1'b0, r_infl});
        mixp    = diff * infl_s;
    end

    // shared multiplier: one digit of the B operand per step, top digit first
    logic [AMW-1:0]     a_sel;
    logic [BPW-1:0]     b_sel;
    logic [DIW-1:0]     nd_m1;
    logic [DIW-1:0]     idx;
    logic [DG-1:0]      digit;
    logic [AMW+DG-1:0]  prod;
    logic [CW-1:0]      acc_next;
    logic               mul_last;
    always_comb begin
        case (i_cmd.op)
            szpd_pkg::OP_DM2: begin
                a_sel = AMW'(r_dm);
                b_sel = BPW'(r_dm);
                nd_m1 = DIW'(ND_SW - 1);
            end
            szpd_pkg::OP_SS: begin
                a_sel = AMW'(r_sm);
                b_sel = BPW'(r_sm);
                nd_m1 = DIW'(ND_SW - 1);
            end
            szpd_pkg::OP_LQ: begin
                a_sel = AMW'(r_len);
                b_sel = BPW'(r_sq);
                nd_m1 = DIW'(ND_QW - 1);
            end
            szpd_pkg::OP_TT: begin
                a_sel = AMW'(r_thr);
                b_sel = BPW'(r_thr);
                nd_m1 = DIW'(ND_TH - 1);
            end
            szpd_pkg::OP_LHS: begin
                a_sel = AMW'(r_len - LW'(1));
                b_sel = BPW'(r_p1);
                nd_m1 = DIW'(ND_PW - 1);
            end
            szpd_pkg::OP_VL: begin
                a_sel = AMW'(r_len);
                b_sel = BPW'(r_var);
                nd_m1 = DIW'(ND_VW - 1);
            end
            szpd_pkg::OP_RHS: begin
                a_sel = AMW'(r_tt);
                b_sel = BPW'(r_vl);
                nd_m1 = DIW'(NDMAX - 1);
            end
            default: begin
                a_sel = '0;
                b_sel = '0;
                nd_m1 = '0;
            end
        endcase
        idx      = nd_m1 - r_dig;
        digit    = b_sel[idx*DG +: DG];
        prod     = a_sel * digit;
        acc_next = ((r_dig == '0) ? CW'(0) : (r_acc << DG)) + CW'(prod);
        mul_last = (r_dig == nd_m1);
    end

    // compare and filtered value
    logic [CW-1:0]         lhs_full;
    logic                  hit;
    logic signed [MXW-1:0] mix;
    logic signed [SB-1:0]  filt_mix;
    always_comb begin
        lhs_full = CW'(r_lhs) << szpd_pkg::THR_SQ_SHIFT;
        hit      = !warm && (lhs_full > r_rhs);
        mix      = (MXW'(r_last) <<< szpd_pkg::INFL_FRAC) + r_mixp;
        filt_mix = mix[szpd_pkg::INFL_FRAC +: SB];
    end

    // update terms
    logic signed [2*SB-1:0] fsq;
    logic signed [2*SB-1:0] osq;
    logic signed [SW-1:0]   old_term;
    logic [QW-1:0]          old_sq_term;
    logic [LW-1:0]          slot_inc;
    always_comb begin
        fsq         = r_filt * r_filt;
        osq         = r_rd * r_rd;
        old_term    = warm ? SW'(0) : SW'(r_rd);
        old_sq_term = warm ? QW'(0) : QW'(r_old_sq);
        slot_inc    = LW'(r_slot) + LW'(1);
    end

    // ring memory; read port follows the write slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_ring[r_slot] <= r_filt;
        end
        r_rd <= r_ring[r_slot];
    end

    always_ff @(posedge i_clk) begin
        r_old_sq <= osq;
        r_var    <= (r_lq >= VW'(r_ss)) ? (r_lq - VW'(r_ss)) : '0;
        if (i_cmd.load) begin
            r_x <= i_sample;
        end
        if (i_cmd.prep) begin
            r_dpos <= !dev[SW] && (dev != '0);
            r_dm   <= dev[SW] ? dev_neg[SW-1:0] : dev[SW-1:0];
            r_sm   <= r_sum[SW-1] ? sum_neg : r_sum;
            r_mixp <= mixp;
        end
        if (i_cmd.mul_step) begin
            r_acc <= acc_next;
            if (mul_last) begin
                case (i_cmd.op)
                    szpd_pkg::OP_DM2: r_p1  <= acc_next[PW-1:0];
                    szpd_pkg::OP_SS:  r_ss  <= acc_next[PW-1:0];
                    szpd_pkg::OP_LQ:  r_lq  <= acc_next[VW-1:0];
                    szpd_pkg::OP_TT:  r_tt  <= acc_next[TSW-1:0];
                    szpd_pkg::OP_LHS: r_lhs <= acc_next[LHW-1:0];
                    szpd_pkg::OP_VL:  r_vl  <= acc_next[RLW-1:0];
                    szpd_pkg::OP_RHS: r_rhs <= acc_next;
                    default:          r_rhs <= acc_next;
                endcase
            end
        end
        if (i_cmd.cmp) begin
            r_filt <= hit ? filt_mix : r_x;
            if (hit) begin
                r_sig <= r_dpos ? szpd_pkg::PEAK_ABOVE : szpd_pkg::PEAK_BELOW;
            end else begin
                r_sig <= szpd_pkg::PEAK_NONE;
            end
        end
        if (i_cmd.sqr) begin
            r_fsq <= fsq;
        end
        if (i_cmd.upd) begin
            r_out_sig  <= r_sig;
            r_out_warm <= warm;
        end
    end

    // control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RST;
            r_thr       <= szpd_pkg::RST_THRESHOLD;
            r_infl      <= szpd_pkg::RST_INFLUENCE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_last      <= '0;
            r_dig       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mul_step) begin
                r_dig <= mul_last ? '0 : r_dig + DIW'(1);
            end
            if (i_cmd.upd) begin
                r_sum       <= r_sum + SW'(r_filt) - old_term;
                r_sq        <= r_sq + QW'(r_fsq) - old_sq_term;
                r_last      <= r_filt;
                r_slot      <= (slot_inc >= r_len) ? '0 : slot_inc[AW-1:0];
                r_out_valid <= 1'b1;
                if (warm) begin
                    r_fill <= r_fill + LW'(1);
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    szpd_pkg::CFG_IDX_WINDOW_LENGTH: begin
                        // new length: empty the window and warm up again
                        r_len  <= wl_eff;
                        r_slot <= '0;
                        r_fill <= '0;
                        r_sum  <= '0;
                        r_sq   <= '0;
                        r_last <= '0;
                    end
                    szpd_pkg::CFG_IDX_THRESHOLD: begin
                        r_thr <= i_cfg_data[szpd_pkg::THR_BITS-1:0];
                    end
                    szpd_pkg::CFG_IDX_INFLUENCE: begin
                        r_infl <= infl_eff;
                    end
                    default: begin
                        r_thr <= r_thr;
                    end
                endcase
            end
        end
    end

    assign o_status.warm     = warm;
    assign o_status.mul_last = mul_last;
    assign o_status.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid    = r_out_valid;
    assign o_peak_signal = r_out_sig;
    assign o_warming_up  = r_out_warm;

    `SZPD_ASSERT(a_fill_le_len, i_clk, i_rst_n, r_fill <= r_len, "fill count above window length")
    `SZPD_ASSERT(a_slot_lt_len, i_clk, i_rst_n, LW'(r_slot) < r_len, "write slot outside window")
    `SZPD_ASSERT(a_dig_idle, i_clk, i_rst_n, !i_cmd.mul_step |-> (r_dig == '0), "digit counter left mid product")

endmodule
